// ===== rtl/hmlp_pkg.sv =====
// ----------------------------------------------------------------------------
// hmlp_pkg
// Types, constants and helper functions for the HID mouse layout parser.
// ----------------------------------------------------------------------------
package hmlp_pkg;

  localparam int STACK_DEPTH = 4;
  localparam int LVL_W = $clog2(STACK_DEPTH + 1);
  localparam int SIDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam logic [7:0] LONG_PREFIX = 8'hFE;
  localparam logic [31:0] USE_X = 32'h30;
  localparam logic [31:0] USE_Y = 32'h31;
  localparam logic [31:0] NOT_SEEN = 32'hFFFF_FFFF;

  // parser phases
  localparam logic [2:0] PH_PREFIX = 3'd0;
  localparam logic [2:0] PH_DATA   = 3'd1;
  localparam logic [2:0] PH_LSIZE  = 3'd2;
  localparam logic [2:0] PH_LTAG   = 3'd3;
  localparam logic [2:0] PH_LSKIP  = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  // item types
  localparam logic [1:0] TY_MAIN = 2'd0;
  localparam logic [1:0] TY_GLB  = 2'd1;
  localparam logic [1:0] TY_LCL  = 2'd2;

  // tags
  localparam logic [3:0] TAG_UPAGE   = 4'h0;
  localparam logic [3:0] TAG_LMIN    = 4'h1;
  localparam logic [3:0] TAG_RSIZE   = 4'h7;
  localparam logic [3:0] TAG_RID     = 4'h8;
  localparam logic [3:0] TAG_RCOUNT  = 4'h9;
  localparam logic [3:0] TAG_PSH     = 4'hA;
  localparam logic [3:0] TAG_POP     = 4'hB;
  localparam logic [3:0] TAG_USG     = 4'h0;
  localparam logic [3:0] TAG_UMIN    = 4'h1;
  localparam logic [3:0] TAG_UMAX    = 4'h2;
  localparam logic [3:0] TAG_INP     = 4'h8;
  localparam logic [3:0] TAG_COLL    = 4'hA;
  localparam logic [3:0] TAG_ENDCOLL = 4'hC;

  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;

  typedef struct packed {
    logic        has_id;
    logic [7:0]  id;
    logic        desktop;
    logic        min_neg;
    logic [15:0] size;
    logic [15:0] count;
  } gset_t;

  typedef struct packed {
    logic        present;
    logic [31:0] off;
    logic [15:0] size;
    logic        sgn;
  } axis_t;

  typedef struct packed {
    logic        valid;
    logic        has_id;
    logic [7:0]  id;
    axis_t       x;
    axis_t       y;
    logic [31:0] bits;
  } saved_t;

  typedef struct packed {
    logic [31:0] total;
    logic [31:0] front;
    logic [31:0] back;
    logic        x_seen;
    logic [31:0] x_idx;
    logic        y_seen;
    logic [31:0] y_idx;
  } usage_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        has_id;
    logic [7:0]  id;
    logic [31:0] x_off;
    logic [15:0] x_size;
    logic        x_sgn;
    logic [31:0] y_off;
    logic [15:0] y_size;
    logic        y_sgn;
    logic [31:0] bits;
  } result_t;

  function automatic logic [31:0] cap32(input logic [33:0] v);
    return (v[33:32] != 2'd0) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic usage_t flush_usage();
    usage_t u;
    u.total = '0;
    u.front = '0;
    u.back = '0;
    u.x_seen = 1'b0;
    u.x_idx = NOT_SEEN;
    u.y_seen = 1'b0;
    u.y_idx = NOT_SEEN;
    return u;
  endfunction

  // append usages lo..hi (signed, inclusive)
  function automatic usage_t add_range(input usage_t u_in, input logic [31:0] lo,
                                       input logic [31:0] hi);
    usage_t u;
    logic [32:0] cnt;
    u = u_in;
    cnt = {1'b0, hi - lo} + 33'd1;
    if ($signed(lo) <= $signed(hi)) begin
      if (u_in.total == 32'd0) u.front = lo;
      u.back = hi;
      if (!u_in.x_seen && $signed(lo) <= $signed(USE_X) && $signed(USE_X) <= $signed(hi)) begin
        u.x_seen = 1'b1;
        u.x_idx = cap32({2'b00, u_in.total} + {2'b00, USE_X - lo});
      end
      if (!u_in.y_seen && $signed(lo) <= $signed(USE_Y) && $signed(USE_Y) <= $signed(hi)) begin
        u.y_seen = 1'b1;
        u.y_idx = cap32({2'b00, u_in.total} + {2'b00, USE_Y - lo});
      end
      u.total = cap32({2'b00, u_in.total} + {1'b0, cnt});
    end
    return u;
  endfunction

endpackage

// ===== rtl/hmlp_core.sv =====
// ----------------------------------------------------------------------------
// hmlp_core
// Per-byte descriptor decode: item assembly, global/local state, collections,
// report cursor and X/Y placement. One byte is consumed per enabled cycle.
// ----------------------------------------------------------------------------
module hmlp_core import hmlp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic [7:0] byte_in,
  input  logic       last_in,
  output result_t    res
);

  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  prefix_r, prefix_nxt;
  logic [31:0] data_r, data_nxt;
  logic [2:0]  left_r, left_nxt;
  logic [2:0]  dlen_r, dlen_nxt;
  logic [7:0]  skip_r, skip_nxt;
  gset_t       gset_r, gset_nxt;
  logic [LVL_W-1:0] lvl_r, lvl_nxt;
  usage_t      use_r, use_nxt;
  logic [31:0] rlow_r, rlow_nxt;
  logic        rset_r, rset_nxt;
  logic [15:0] depth_r, depth_nxt;
  logic        mouse_r, mouse_nxt;
  logic        rhid_r, rhid_nxt;
  logic [7:0]  rid_r, rid_nxt;
  logic [31:0] cur_r, cur_nxt;
  axis_t       xa_r, xa_nxt, ya_r, ya_nxt;
  saved_t      sv_r, sv_nxt;

  gset_t       stack_mem [STACK_DEPTH];
  logic        push_en;
  logic [LVL_W-1:0] lvl_dec;

  logic        trunc, ex;
  logic [7:0]  ex_p;
  logic [31:0] ex_d;
  logic [2:0]  ex_n, dl;
  logic [1:0]  shift;
  logic [31:0] xprod, yprod, cu;
  logic [31:0] rprod;
  logic        in_ok;

  assign xprod = use_r.x_idx * {16'd0, gset_r.size};
  assign yprod = use_r.y_idx * {16'd0, gset_r.size};
  assign rprod = {16'd0, gset_r.size} * {16'd0, gset_r.count};
  assign lvl_dec = lvl_r - 1'b1;

  function automatic saved_t commit(input saved_t s, input logic hid, input logic [7:0] id,
                                    input axis_t x, input axis_t y, input logic [31:0] c);
    saved_t o;
    o = s;
    if (x.present && y.present && !s.valid) begin
      o.valid = 1'b1;
      o.has_id = hid;
      o.id = id;
      o.x = x;
      o.y = y;
      o.bits = c;
    end
    return o;
  endfunction

  always_comb begin
    phase_nxt = phase_r;  prefix_nxt = prefix_r; data_nxt = data_r;
    left_nxt = left_r;    dlen_nxt = dlen_r;     skip_nxt = skip_r;
    gset_nxt = gset_r;    lvl_nxt = lvl_r;       use_nxt = use_r;
    rlow_nxt = rlow_r;    rset_nxt = rset_r;     depth_nxt = depth_r;
    mouse_nxt = mouse_r;  rhid_nxt = rhid_r;     rid_nxt = rid_r;
    cur_nxt = cur_r;      xa_nxt = xa_r;         ya_nxt = ya_r;
    sv_nxt = sv_r;
    push_en = 1'b0;
    trunc = 1'b0; ex = 1'b0; ex_p = byte_in; ex_d = '0; ex_n = '0;
    dl = (byte_in[1:0] == 2'd3) ? 3'd4 : {1'b0, byte_in[1:0]};
    shift = 2'(dlen_r - left_r);
    cu = (use_r.total != 32'd0) ? use_r.front : 32'd0;
    in_ok = 1'b0;
    res = '0;

    unique case (phase_r)
      PH_PREFIX: begin
        if (byte_in == LONG_PREFIX) begin
          if (last_in) trunc = 1'b1;
          else phase_nxt = PH_LSIZE;
        end else begin
          prefix_nxt = byte_in;
          data_nxt = '0;
          dlen_nxt = dl;
          left_nxt = dl;
          if (dl == 3'd0) ex = 1'b1;
          else if (last_in) trunc = 1'b1;
          else phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        data_nxt = data_r | ({24'd0, byte_in} << {shift, 3'b000});
        left_nxt = left_r - 3'd1;
        if (left_r == 3'd1) begin
          phase_nxt = PH_PREFIX;
          ex = 1'b1;
          ex_p = prefix_r;
          ex_d = data_nxt;
          ex_n = dlen_r;
        end else if (last_in) begin
          trunc = 1'b1;
        end
      end
      PH_LSIZE: begin
        skip_nxt = byte_in;
        if (last_in) trunc = 1'b1;
        else phase_nxt = PH_LTAG;
      end
      PH_LTAG: phase_nxt = (skip_r != 8'd0) ? PH_LSKIP : PH_PREFIX;
      PH_LSKIP: begin
        skip_nxt = skip_r - 8'd1;
        if (skip_r == 8'd1) phase_nxt = PH_PREFIX;
      end
      default: ;
    endcase

    if (ex) begin
      unique case (ex_p[3:2])
        TY_GLB: begin
          unique case (ex_p[7:4])
            TAG_UPAGE: gset_nxt.desktop = (ex_d == 32'd1);
            TAG_LMIN: begin
              unique case (ex_n)
                3'd1:    gset_nxt.min_neg = ex_d[7];
                3'd2:    gset_nxt.min_neg = ex_d[15];
                3'd4:    gset_nxt.min_neg = ex_d[31];
                default: gset_nxt.min_neg = 1'b0;
              endcase
            end
            TAG_RSIZE:  gset_nxt.size = ex_d[15:0];
            TAG_RCOUNT: gset_nxt.count = ex_d[15:0];
            TAG_RID: begin
              gset_nxt.has_id = 1'b1;
              gset_nxt.id = ex_d[7:0];
              if (rid_r != ex_d[7:0] || !rhid_r) begin
                sv_nxt = commit(sv_r, rhid_r, rid_r, xa_r, ya_r, cur_r);
                xa_nxt = '0;
                ya_nxt = '0;
                cur_nxt = '0;
                rhid_nxt = 1'b1;
                rid_nxt = ex_d[7:0];
              end
            end
            TAG_PSH: begin
              if (lvl_r < LVL_W'(STACK_DEPTH)) begin
                push_en = 1'b1;
                lvl_nxt = lvl_r + 1'b1;
              end
            end
            TAG_POP: begin
              if (lvl_r != '0) begin
                gset_nxt = stack_mem[lvl_dec[SIDX_W-1:0]];
                lvl_nxt = lvl_dec;
              end
            end
            default: ;
          endcase
        end
        TY_LCL: begin
          if (ex_p[7:4] == TAG_USG) begin
            use_nxt = add_range(use_r, ex_d, ex_d);
          end else if (ex_p[7:4] == TAG_UMIN) begin
            rlow_nxt = ex_d;
            rset_nxt = 1'b1;
          end else if (ex_p[7:4] == TAG_UMAX && rset_r) begin
            use_nxt = add_range(use_r, rlow_r, ex_d);
            rset_nxt = 1'b0;
          end
        end
        TY_MAIN: begin
          if (ex_p[7:4] == TAG_COLL) begin
            if (gset_r.desktop && (cu == 32'h2 || cu == 32'h1)) mouse_nxt = 1'b1;
            if (depth_r != 16'hFFFF) depth_nxt = depth_r + 16'd1;
          end else if (ex_p[7:4] == TAG_ENDCOLL) begin
            if (depth_r <= 16'd1) begin
              depth_nxt = '0;
              sv_nxt = commit(sv_r, rhid_r, rid_r, xa_r, ya_r, cur_r);
              if (mouse_r && sv_nxt.valid) phase_nxt = PH_DONE;
              mouse_nxt = 1'b0;
            end else begin
              depth_nxt = depth_r - 16'd1;
            end
          end else if (ex_p[7:4] == TAG_INP) begin
            in_ok = mouse_r && ex_d[1] && !ex_d[0] && ex_d[2] && gset_r.desktop;
            if (in_ok && !xa_r.present && use_r.x_seen &&
                use_r.x_idx < {16'd0, gset_r.count}) begin
              xa_nxt.present = 1'b1;
              xa_nxt.off = cur_r + xprod;
              xa_nxt.size = gset_r.size;
              xa_nxt.sgn = gset_r.min_neg;
            end
            if (in_ok && !ya_r.present && use_r.y_seen &&
                use_r.y_idx < {16'd0, gset_r.count}) begin
              ya_nxt.present = 1'b1;
              ya_nxt.off = cur_r + yprod;
              ya_nxt.size = gset_r.size;
              ya_nxt.sgn = gset_r.min_neg;
            end
            cur_nxt = cur_r + rprod;
          end
          use_nxt = flush_usage();
          rlow_nxt = '0;
          rset_nxt = 1'b0;
        end
        default: ;
      endcase
    end

    // result on the final byte
    if (trunc) begin
      res.status = ST_TRUNC;
    end else if (last_in) begin
      sv_nxt = commit(sv_nxt, rhid_nxt, rid_nxt, xa_nxt, ya_nxt, cur_nxt);
      if (sv_nxt.valid) begin
        res.status = ST_FOUND;
        res.has_id = sv_nxt.has_id;
        res.id = sv_nxt.id;
        res.x_off = sv_nxt.x.off;
        res.x_size = sv_nxt.x.size;
        res.x_sgn = sv_nxt.x.sgn;
        res.y_off = sv_nxt.y.off;
        res.y_size = sv_nxt.y.size;
        res.y_sgn = sv_nxt.y.sgn;
        res.bits = sv_nxt.bits;
      end else begin
        res.status = ST_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && push_en) stack_mem[lvl_r[SIDX_W-1:0]] <= gset_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (en && last_in)) begin
      phase_r <= PH_PREFIX; prefix_r <= '0; data_r <= '0; left_r <= '0; dlen_r <= '0;
      skip_r <= '0; gset_r <= '0; lvl_r <= '0; use_r <= flush_usage();
      rlow_r <= '0; rset_r <= 1'b0; depth_r <= '0; mouse_r <= 1'b0;
      rhid_r <= 1'b0; rid_r <= '0; cur_r <= '0; xa_r <= '0; ya_r <= '0; sv_r <= '0;
    end else if (en) begin
      phase_r <= phase_nxt; prefix_r <= prefix_nxt; data_r <= data_nxt;
      left_r <= left_nxt; dlen_r <= dlen_nxt; skip_r <= skip_nxt;
      gset_r <= gset_nxt; lvl_r <= lvl_nxt; use_r <= use_nxt;
      rlow_r <= rlow_nxt; rset_r <= rset_nxt; depth_r <= depth_nxt; mouse_r <= mouse_nxt;
      rhid_r <= rhid_nxt; rid_r <= rid_nxt; cur_r <= cur_nxt;
      xa_r <= xa_nxt; ya_r <= ya_nxt; sv_r <= sv_nxt;
    end
  end

endmodule

// ===== rtl/hid_mouse_layout_parser.sv =====
// ----------------------------------------------------------------------------
// hid_mouse_layout_parser
// Finds the X/Y fields of a mouse report in a HID report descriptor.
// ----------------------------------------------------------------------------
// Channel | Direction | Contents
// in_     | slave     | tdata[7:0] descriptor byte, tlast = final byte
// out_    | master    | tdata = layout result, one per descriptor
//
// One byte per cycle sustained while no final byte waits. The byte register
// feeds the decode logic, whose result goes to an output register, from which
// it is presented. Only a final byte waits on a full output register; other
// bytes keep flowing. Reset is synchronous, active low; the parser state also
// returns to reset after every result.
// ----------------------------------------------------------------------------
module hid_mouse_layout_parser import hmlp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // desc_byte
  input  logic         in_tlast,   // last_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[1:0], id_present[2], rep_id[10:3], x_bit_offset[42:11],
  // x_bit_size[58:43], x_signed[59], y_bit_offset[91:60], y_bit_size[107:92],
  // y_signed[108], rep_bits[140:109], zero fill [143:141]
  output logic [143:0] out_tdata
);

  logic       vld_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       out_free, adv;
  result_t    res;
  logic       ovld_r;
  result_t    ores_r;

  assign out_free = !ovld_r || out_tready;
  assign adv = vld_r && (!last_r || out_free);
  assign in_tready = !vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  hmlp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .byte_in (byte_r),
    .last_in (last_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (adv && last_r) begin
      ovld_r <= 1'b1;
    end else if (out_tready) begin
      ovld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && last_r) ores_r <= res;
  end

  assign out_tvalid = ovld_r;
  assign out_tdata = {3'b000, ores_r.bits, ores_r.y_sgn, ores_r.y_size, ores_r.y_off,
                      ores_r.x_sgn, ores_r.x_size, ores_r.x_off, ores_r.id,
                      ores_r.has_id, ores_r.status};

endmodule

// ===== tb/sv/hid_mouse_layout_parser_tb.sv =====
// ----------------------------------------------------------------------------
// hid_mouse_layout_parser_tb
// Streams generated HID report descriptors into the parser, predicts the
// layout result of each descriptor and checks every result transaction.
// ----------------------------------------------------------------------------
module hid_mouse_layout_parser_tb;
  import hmlp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // item prefix byte: tag[7:4], type[3:2], size code[1:0]
  function automatic logic [7:0] pfx(logic [3:0] tag, logic [1:0] typ, logic [1:0] sz);
    return {tag, typ, sz};
  endfunction

  // ------------------------------------------------------------------
  // layout predictor: tracks the parser state byte by byte
  // ------------------------------------------------------------------
  class layout_scoreboard;
    logic [2:0] phase;
    logic [7:0] prefix;
    logic [31:0] data;
    int unsigned nleft, nlen;
    logic [7:0] skip_left;
    gset_t gs;
    gset_t gstack[STACK_DEPTH];
    int unsigned level;
    usage_t us;
    logic [31:0] rlo;
    logic rset;
    logic [15:0] cdepth;
    logic mouse;
    logic rhas;
    logic [7:0] rid;
    logic [31:0] cursor;
    axis_t xa, ya;
    saved_t sv;
    result_t pending[$];
    int errors;

    function void clear();
      phase = PH_PREFIX; prefix = 0; data = 0; nleft = 0; nlen = 0; skip_left = 0;
      gs = '0; level = 0; clear_usage(); cdepth = 0; mouse = 0;
      rhas = 0; rid = 0; cursor = 0; xa = '0; ya = '0; sv = '0;
    endfunction

    function void clear_usage();
      us.total = 0; us.front = 0; us.back = 0;
      us.x_seen = 0; us.y_seen = 0; us.x_idx = '1; us.y_idx = '1;
      rlo = 0; rset = 0;
    endfunction

    function logic [31:0] sat(logic [33:0] v);
      return (v[33:32] != 0) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function void fold_range(logic [31:0] lo, logic [31:0] hi);
      logic [32:0] n;
      usage_t o;
      o = us;
      if ($signed(lo) > $signed(hi)) return;
      n = {1'b0, hi - lo} + 33'd1;
      if (o.total == 0) us.front = lo;
      us.back = hi;
      if (!o.x_seen && $signed(lo) <= 32'sh30 && 32'sh30 <= $signed(hi)) begin
        us.x_seen = 1; us.x_idx = sat({2'b0, o.total} + {2'b0, USE_X - lo});
      end
      if (!o.y_seen && $signed(lo) <= 32'sh31 && 32'sh31 <= $signed(hi)) begin
        us.y_seen = 1; us.y_idx = sat({2'b0, o.total} + {2'b0, USE_Y - lo});
      end
      us.total = sat({2'b0, o.total} + {1'b0, n});
    endfunction

    function void latch_report();
      if (xa.present && ya.present && !sv.valid) begin
        sv.valid = 1; sv.has_id = rhas; sv.id = rid; sv.x = xa; sv.y = ya; sv.bits = cursor;
      end
    endfunction

    function axis_t locate(axis_t a, logic seen, logic [31:0] idx);
      axis_t r;
      r = a;
      if (!a.present && seen && idx < {16'd0, gs.count}) begin
        r.present = 1; r.off = cursor + idx * {16'd0, gs.size};
        r.size = gs.size; r.sgn = gs.min_neg;
      end
      return r;
    endfunction

    function void run_item(logic [7:0] p, logic [31:0] d, int unsigned n);
      logic [1:0] typ;
      logic [3:0] tag;
      logic [31:0] cu;
      typ = p[3:2]; tag = p[7:4];
      if (typ == TY_GLB) begin
        case (tag)
          TAG_UPAGE: gs.desktop = (d == 1);
          TAG_LMIN: gs.min_neg = n ? d[8*n-1] : 1'b0;
          TAG_RSIZE: gs.size = d[15:0];
          TAG_RCOUNT: gs.count = d[15:0];
          TAG_RID: begin
            gs.has_id = 1; gs.id = d[7:0];
            if (rid != gs.id || !rhas) begin
              latch_report(); xa = '0; ya = '0; cursor = 0; rhas = 1; rid = gs.id;
            end
          end
          TAG_PSH: if (level < STACK_DEPTH) begin gstack[level] = gs; level++; end
          TAG_POP: if (level > 0) begin level--; gs = gstack[level]; end
          default: ;
        endcase
      end else if (typ == TY_LCL) begin
        if (tag == TAG_USG) fold_range(d, d);
        else if (tag == TAG_UMIN) begin rlo = d; rset = 1; end
        else if (tag == TAG_UMAX && rset) begin fold_range(rlo, d); rset = 0; end
      end else if (typ == TY_MAIN) begin
        if (tag == TAG_COLL) begin
          cu = us.total ? us.front : 0;
          if (gs.desktop && (cu == 2 || cu == 1)) mouse = 1;
          if (cdepth != 16'hFFFF) cdepth++;
        end else if (tag == TAG_ENDCOLL) begin
          if (cdepth > 0) cdepth--;
          if (cdepth == 0) begin
            latch_report();
            if (mouse && sv.valid) phase = PH_DONE;
            mouse = 0;
          end
        end else if (tag == TAG_INP) begin
          if (mouse && d[1] && !d[0] && d[2] && gs.desktop) begin
            xa = locate(xa, us.x_seen, us.x_idx);
            ya = locate(ya, us.y_seen, us.y_idx);
          end
          cursor += {16'd0, gs.size} * {16'd0, gs.count};
        end
        clear_usage();
      end
    endfunction

    // accepted input transaction
    function void note_byte(logic [7:0] b, logic last);
      logic trunc;
      result_t r;
      trunc = 0;
      case (phase)
        PH_PREFIX: begin
          if (b == LONG_PREFIX) begin
            if (last) trunc = 1; else phase = PH_LSIZE;
          end else begin
            prefix = b; data = 0;
            nlen = (b[1:0] == 3) ? 4 : b[1:0];
            nleft = nlen;
            if (nlen == 0) run_item(b, 0, 0);
            else if (last) trunc = 1;
            else phase = PH_DATA;
          end
        end
        PH_DATA: begin
          data |= {24'd0, b} << (8 * ((nlen - nleft) & 3));
          nleft--;
          if (nleft == 0) begin
            phase = PH_PREFIX; run_item(prefix, data, nlen);
          end else if (last) trunc = 1;
        end
        PH_LSIZE: begin
          skip_left = b;
          if (last) trunc = 1; else phase = PH_LTAG;
        end
        PH_LTAG: phase = skip_left ? PH_LSKIP : PH_PREFIX;
        PH_LSKIP: begin
          skip_left--;
          if (skip_left == 0) phase = PH_PREFIX;
        end
        default: ;
      endcase
      if (!last) return;
      r = '0;
      if (trunc) r.status = ST_TRUNC;
      else begin
        latch_report();
        if (sv.valid) begin
          r.status = ST_FOUND; r.has_id = sv.has_id; r.id = sv.id;
          r.x_off = sv.x.off; r.x_size = sv.x.size; r.x_sgn = sv.x.sgn;
          r.y_off = sv.y.off; r.y_size = sv.y.size; r.y_sgn = sv.y.sgn;
          r.bits = sv.bits;
        end else r.status = ST_NONE;
      end
      pending.insert(pending.size(), r);
      clear();
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
    endfunction

    // accepted result transaction
    function void check_result(logic [143:0] t);
      result_t e;
      if (pending.size() == 0) begin
        $display("unexpected layout result %h", t);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (t[1:0] != e.status) report("status", t[1:0], e.status);
      if (t[2] != e.has_id) report("id_present", t[2], e.has_id);
      if (t[10:3] != e.id) report("rep_id", t[10:3], e.id);
      if (t[42:11] != e.x_off) report("x_bit_offset", t[42:11], e.x_off);
      if (t[58:43] != e.x_size) report("x_bit_size", t[58:43], e.x_size);
      if (t[59] != e.x_sgn) report("x_signed", t[59], e.x_sgn);
      if (t[91:60] != e.y_off) report("y_bit_offset", t[91:60], e.y_off);
      if (t[107:92] != e.y_size) report("y_bit_size", t[107:92], e.y_size);
      if (t[108] != e.y_sgn) report("y_signed", t[108], e.y_sgn);
      if (t[140:109] != e.bits) report("rep_bits", t[140:109], e.bits);
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tlast = 0, out_tready = 0;
  logic [7:0] in_tdata = 0;
  logic in_tready, out_tvalid;
  logic [143:0] out_tdata;

  hid_mouse_layout_parser uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  layout_scoreboard sb = new();
  int send_idle_pct, recv_idle_pct;
  bit hold_off;
  int stall_cycles;
  int sent;

  always @(posedge clk) if (rst_n) begin
    if (in_tvalid && in_tready) sb.note_byte(in_tdata, in_tlast);
    if (out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 0;
    else if (hold_off && stall_cycles < 300) begin
      stall_cycles++;
      out_tready <= 0;
    end else out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog
  int quiet;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
    else quiet++;
    if (quiet > 5000) begin
      $display("hid_mouse_layout_parser_tb NOT OK");
      $finish;
    end
  end

  // one descriptor under construction
  logic [7:0] desc[$];

  function automatic void app(logic [7:0] b);
    desc.insert(desc.size(), b);
  endfunction

  task automatic put_item(logic [3:0] tag, logic [1:0] typ, logic [31:0] d, int n);
    app(pfx(tag, typ, (n == 4) ? 2'd3 : n[1:0]));
    for (int i = 0; i < n; i++) app(d[8*i +: 8]);
  endtask

  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1; in_tdata <= b; in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send_desc();
    for (int i = 0; i < desc.size(); i++) send_byte(desc[i], i == desc.size() - 1);
    desc.delete();
  endtask

  function automatic int rsize();
    int k;
    k = $urandom_range(9);
    return (k < 3) ? 0 : (k < 5) ? 1 : (k < 7) ? 2 : 4;
  endfunction

  // mouse descriptor with random content and an optional random trailing byte
  task automatic build_mouse();
    int nrep;
    put_item(TAG_UPAGE, TY_GLB, $urandom_range(3) ? 1 : 2, 1);
    put_item(TAG_USG, TY_LCL, $urandom_range(1) ? 2 : 1, 1);
    put_item(TAG_COLL, TY_MAIN, 1, 1);
    nrep = $urandom_range(1, 3);
    for (int r = 0; r < nrep; r++) begin
      if ($urandom_range(1)) put_item(TAG_RID, TY_GLB, $urandom_range(255), 1);
      if ($urandom_range(3) == 0) put_item(TAG_PSH, TY_GLB, 0, 0);
      put_item(TAG_RSIZE, TY_GLB, $urandom_range(3) ? $urandom_range(1, 16) : $urandom,
               $urandom_range(3) ? 1 : 4);
      put_item(TAG_RCOUNT, TY_GLB, $urandom_range(1, 4), 1);
      put_item(TAG_INP, TY_MAIN, 2, 1);
      put_item(TAG_LMIN, TY_GLB, $urandom, rsize());
      put_item(TAG_RCOUNT, TY_GLB, $urandom_range(1, 5), 1);
      if ($urandom_range(1)) begin
        put_item(TAG_UMIN, TY_LCL, $urandom_range(1) ? 32'h30 : $urandom_range(32'h2e, 32'h31), 1);
        put_item(TAG_UMAX, TY_LCL, $urandom_range(32'h2f, 32'h38), 1);
      end else begin
        if ($urandom_range(1)) put_item(TAG_USG, TY_LCL, 32'h38, 1);
        put_item(TAG_USG, TY_LCL, USE_X, 1);
        put_item(TAG_USG, TY_LCL, USE_Y, rsize() == 0 ? 1 : 2);
      end
      put_item(TAG_INP, TY_MAIN, $urandom_range(1) ? 6 : $urandom_range(7), 1);
      if ($urandom_range(3) == 0) put_item(TAG_POP, TY_GLB, 0, 0);
    end
    put_item(TAG_ENDCOLL, TY_MAIN, 0, 0);
    if ($urandom_range(1)) app(8'($urandom));
  endtask

  task automatic build_noise(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(4))
        0: put_item(4'($urandom), 2'($urandom), $urandom, rsize());
        1: begin
          app(LONG_PREFIX);
          app(8'($urandom_range(3))); app(8'($urandom));
          repeat (desc[$ - 1]) app(8'($urandom));
        end
        2: put_item($urandom_range(1) ? TAG_PSH : TAG_POP, TY_GLB, 0, 0);
        3: put_item($urandom_range(1) ? TAG_COLL : TAG_ENDCOLL, TY_MAIN, $urandom, 1);
        default: app(8'($urandom));
      endcase
    end
  endtask

  task automatic random_phase(int nbytes);
    int stop;
    stop = sent + nbytes;
    while (sent < stop) begin
      case ($urandom_range(9))
        0, 1: build_noise($urandom_range(1, 12));
        2: begin
          build_mouse();
          desc = desc[0 : $urandom_range(desc.size() - 1)];  // cut short
        end
        default: begin
          if ($urandom_range(3) == 0) build_noise($urandom_range(1, 3));
          build_mouse();
        end
      endcase
      send_desc();
    end
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    send_idle_pct = 0; recv_idle_pct = 0;

    // directed: extremes, long items, truncation, stack limits, saturation
    desc = '{8'h00}; send_desc();
    desc = '{8'hFF}; send_desc();
    desc = '{LONG_PREFIX}; send_desc();
    desc = '{LONG_PREFIX, 8'h02}; send_desc();
    desc = '{LONG_PREFIX, 8'h02, 8'h00, 8'hAA}; send_desc();
    desc = '{8'h27, 8'h01, 8'h02}; send_desc();
    repeat (6) put_item(TAG_PSH, TY_GLB, 0, 0);
    repeat (6) put_item(TAG_POP, TY_GLB, 0, 0);
    put_item(TAG_ENDCOLL, TY_MAIN, 0, 0);
    put_item(TAG_UMAX, TY_LCL, 5, 1);
    put_item(TAG_UMIN, TY_LCL, 32'h7FFF_FFFF, 4);
    put_item(TAG_UMAX, TY_LCL, 32'h8000_0000, 4);
    put_item(TAG_UMIN, TY_LCL, 32'h8000_0000, 4);
    put_item(TAG_UMAX, TY_LCL, 32'h7FFF_FFFF, 4);
    put_item(TAG_UMIN, TY_LCL, 0, 0);
    put_item(TAG_UMAX, TY_LCL, 32'h7FFF_FFFF, 4);
    put_item(TAG_COLL, TY_MAIN, 0, 0);
    put_item(4'hF, 2'd3, 32'hFFFF_FFFF, 4);
    send_desc();
    build_mouse(); send_desc();
    drain();

    send_idle_pct = 23; recv_idle_pct = 62;
    random_phase(450);
    // receiver holds off while input keeps flowing
    stall_cycles = 0; hold_off = 1;
    random_phase(200);
    hold_off = 0;
    drain();
    send_idle_pct = 62; recv_idle_pct = 23;
    random_phase(450);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(450);
    drain();

    if (sb.errors == 0) $display("hid_mouse_layout_parser_tb OK");
    else $display("hid_mouse_layout_parser_tb NOT OK");
    $finish;
  end
endmodule
